FILE: design/aetp_pkg.sv
// shared types, character codes and colour tables of the escape parser
package aetp_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_CURSOR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CLS_CTRL  = 3'd0,
        CLS_PRINT = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_SEP   = 3'd3,
        CLS_HIGH  = 3'd4
    } cls_t;

    typedef struct packed {
        logic [7:0] data;
        cls_t       cls;
    } byte_item_t;

    typedef struct packed {
        cmd_t              command;
        logic [7:0]        left_col;
        logic [7:0]        top_row;
        logic [7:0]        right_col;
        logic [7:0]        bottom_row;
        logic signed [8:0] scroll_amount;
        logic [6:0]        glyph;
        logic [23:0]       fg_rgb;
        logic [23:0]       bg_rgb;
        logic [8:0]        text_flags;
        logic              last;
    } result_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
    localparam logic [23:0] RGB_BLACK = 24'h000000;
    localparam logic [23:0] RGB_GREY  = 24'hAAAAAA;

    function automatic logic [23:0] base16(input logic [3:0] i);
        logic [23:0] c;
        unique case (i)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'hAA0000;
            4'd2:  c = 24'h00AA00;
            4'd3:  c = 24'hAA5500;
            4'd4:  c = 24'h0000AA;
            4'd5:  c = 24'hAA00AA;
            4'd6:  c = 24'h00AAAA;
            4'd7:  c = 24'hAAAAAA;
            4'd8:  c = 24'h555555;
            4'd9:  c = 24'hFF5555;
            4'd10: c = 24'h55FF55;
            4'd11: c = 24'hFFFF55;
            4'd12: c = 24'h5555FF;
            4'd13: c = 24'hFF55FF;
            4'd14: c = 24'h55FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] x);
        logic [7:0] v;
        unique case (x)
            3'd0: v = 8'h00;
            3'd1: v = 8'h5F;
            3'd2: v = 8'h87;
            3'd3: v = 8'hAF;
            3'd4: v = 8'hD7;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    // 256 colour palette; cube digits by reciprocal multiply (exact for k < 216)
    function automatic logic [23:0] palette(input logic [7:0] i);
        logic [7:0]  k;
        logic [13:0] p1;
        logic [2:0]  q1;
        logic [7:0]  r8;
        logic [5:0]  r36;
        logic [11:0] p2;
        logic [2:0]  q2;
        logic [5:0]  q3w;
        logic [7:0]  g;
        logic [23:0] c;
        k   = i - 8'd16;
        p1  = 14'(k) * 14'd57;
        q1  = p1[13:11];
        r8  = k - 8'(q1) * 8'd36;
        r36 = r8[5:0];
        p2  = 12'(r36) * 12'd43;
        q2  = p2[10:8];
        q3w = r36 - 6'(q2) * 6'd6;
        g   = 8'd8 + 8'd10 * (i - 8'd232);
        if (i < 8'd16) begin
            c = base16(i[3:0]);
        end else if (i < 8'd232) begin
            c = {cube_level(q1), cube_level(q2), cube_level(q3w[2:0])};
        end else begin
            c = {g, g, g};
        end
        return c;
    endfunction

endpackage

FILE: design/aetp_fifo.sv
// small first-in first-out queue of register entries
module aetp_fifo
    import aetp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/aetp_front.sv
// input stage: takes bytes and tags each with its character class
module aetp_front
    import aetp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_byte,
    output logic       full,
    input  logic       q_full,
    output logic       q_push,
    output byte_item_t q_item
);
    logic       valid_reg, valid_next;
    byte_item_t stage_reg;
    logic       take;
    cls_t       cls;

    always_comb
    begin
        if (in_byte[7])
        begin
            cls = CLS_HIGH;
        end
        else if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            cls = CLS_DIGIT;
        end
        else if (in_byte == CH_SEMI || in_byte == CH_COLON)
        begin
            cls = CLS_SEP;
        end
        else if (in_byte >= CH_SPACE && in_byte != CH_DEL)
        begin
            cls = CLS_PRINT;
        end
        else
        begin
            cls = CLS_CTRL;
        end
    end

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_item = stage_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= '{data: in_byte, cls: cls};
        end
    end

endmodule

FILE: design/aetp_back.sv
// execution stage: parser state, cursor, attributes and command generation
module aetp_back
    import aetp_pkg::*;
#(
    parameter int MAX_ARGS = 8,
    parameter int TAB_STOP = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  byte_item_t in_item,
    output logic       in_ready,
    input  logic       out_full,
    output logic       out_push,
    output result_t    out_item
);
    localparam int TW = $clog2(MAX_ARGS + 1);
    localparam int IW = $clog2(MAX_ARGS);
    localparam int NA = 5;
    // reciprocal of the tab width, exact for any 8 bit column
    localparam int TAB_RECIP = (65536 + TAB_STOP - 1) / TAB_STOP;

    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CNL = 8'h45;
    localparam logic [7:0] FIN_CPL = 8'h46;
    localparam logic [7:0] FIN_CHA = 8'h47;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_SU  = 8'h53;
    localparam logic [7:0] FIN_SD  = 8'h54;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_SCP = 8'h73;
    localparam logic [7:0] FIN_RCP = 8'h75;

    localparam logic [7:0] ESC_CSI = 8'h5B;
    localparam logic [7:0] ESC_SS2 = 8'h4E;
    localparam logic [7:0] ESC_SS3 = 8'h4F;
    localparam logic [7:0] ESC_DCS = 8'h50;
    localparam logic [7:0] ESC_ST  = 8'h5C;
    localparam logic [7:0] ESC_OSC = 8'h5D;
    localparam logic [7:0] ESC_SOS = 8'h58;
    localparam logic [7:0] ESC_PM  = 8'h5E;
    localparam logic [7:0] ESC_APC = 8'h5F;

    localparam logic [15:0] SGR_RESET     = 16'd0;
    localparam logic [15:0] SGR_BOLD      = 16'd1;
    localparam logic [15:0] SGR_DIM       = 16'd2;
    localparam logic [15:0] SGR_ITALIC    = 16'd3;
    localparam logic [15:0] SGR_UNDER     = 16'd4;
    localparam logic [15:0] SGR_BLINK     = 16'd5;
    localparam logic [15:0] SGR_RBLINK    = 16'd6;
    localparam logic [15:0] SGR_REVERSE   = 16'd7;
    localparam logic [15:0] SGR_HIDE      = 16'd8;
    localparam logic [15:0] SGR_STRIKE    = 16'd9;
    localparam logic [15:0] SGR_NORMAL    = 16'd22;
    localparam logic [15:0] SGR_NOITALIC  = 16'd23;
    localparam logic [15:0] SGR_NOUNDER   = 16'd24;
    localparam logic [15:0] SGR_NOBLINK   = 16'd25;
    localparam logic [15:0] SGR_NOREVERSE = 16'd27;
    localparam logic [15:0] SGR_SHOW      = 16'd28;
    localparam logic [15:0] SGR_NOSTRIKE  = 16'd29;
    localparam logic [15:0] SGR_FG_EXT    = 16'd38;
    localparam logic [15:0] SGR_FG_DEF    = 16'd39;
    localparam logic [15:0] SGR_BG_EXT    = 16'd48;
    localparam logic [15:0] SGR_BG_DEF    = 16'd49;
    localparam logic [15:0] SGR_OVER      = 16'd53;
    localparam logic [15:0] SGR_NOOVER    = 16'd55;
    localparam logic [15:0] SEL_INDEXED   = 16'd5;
    localparam logic [15:0] SEL_DIRECT    = 16'd2;

    localparam logic [8:0] ATTR_BLINK   = 9'h003;
    localparam logic [8:0] ATTR_BOLD    = 9'h004;
    localparam logic [8:0] ATTR_DIM     = 9'h008;
    localparam logic [8:0] ATTR_ITALIC  = 9'h010;
    localparam logic [8:0] ATTR_UNDER   = 9'h020;
    localparam logic [8:0] ATTR_STRIKE  = 9'h040;
    localparam logic [8:0] ATTR_OVER    = 9'h080;
    localparam logic [8:0] ATTR_REVERSE = 9'h100;

    mode_t       mode_reg, mode_next;
    logic [15:0] args_reg [MAX_ARGS];
    logic [15:0] args_next [MAX_ARGS];
    logic [TW-1:0] total_reg, total_next;
    logic        innum_reg, innum_next;
    logic [7:0]  col_reg, col_next, row_reg, row_next;
    logic [7:0]  scol_reg, scol_next, srow_reg, srow_next;
    logic [23:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [8:0]  attr_reg, attr_next;
    logic [7:0]  cols_reg, cols_next, rows_reg, rows_next;
    result_t     pend_reg [3];
    result_t     pend_next [3];
    logic [1:0]  pcnt_reg, pcnt_next, pidx_reg, pidx_next;

    logic        take;
    logic [7:0]  w, h, wm1, hm1;
    logic [7:0]  tot8;
    logic [15:0] argv [NA];
    logic [15:0] n, n1, p1;
    logic [7:0]  pidx;
    logic [23:0] pal;
    logic [24:0] tab_prod;
    logic [8:0]  tab_col;
    logic [IW-1:0] aidx;
    logic [19:0] prod;

    function automatic logic [7:0] clamp_to(input logic [15:0] v, input logic [7:0] lim);
        return (v > 16'(lim)) ? lim : v[7:0];
    endfunction

    function automatic result_t mk(input cmd_t c, input logic [7:0] l, input logic [7:0] t,
                                   input logic [7:0] r, input logic [7:0] b,
                                   input logic signed [8:0] amt, input logic [6:0] g);
        result_t o;
        o               = '0;
        o.command       = c;
        o.left_col      = l;
        o.top_row       = t;
        o.right_col     = r;
        o.bottom_row    = b;
        o.scroll_amount = amt;
        o.glyph         = g;
        return o;
    endfunction

    assign w    = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
    assign h    = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign wm1  = w - 8'd1;
    assign hm1  = h - 8'd1;
    assign tot8 = 8'(total_reg);

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            argv[k] = '0;
        end
        for (int k = 0; k < MAX_ARGS; k++)
        begin
            if (k < NA && tot8 > 8'(k))
            begin
                argv[3'(k)] = args_reg[k];
            end
        end
    end

    assign n  = (tot8 == 8'd0) ? 16'd1 : argv[0];
    assign n1 = (n == 16'd0) ? 16'd0 : n - 16'd1;
    assign p1 = (tot8 < 8'd2) ? 16'd0 : ((argv[1] == 16'd0) ? 16'd0 : argv[1] - 16'd1);

    // one palette lookup shared by the plain, bright and indexed extended colour forms
    always_comb
    begin
        if (argv[0] >= 16'd30 && argv[0] <= 16'd37)
        begin
            pidx = argv[0][7:0] - 8'd30;
        end
        else if (argv[0] >= 16'd40 && argv[0] <= 16'd47)
        begin
            pidx = argv[0][7:0] - 8'd40;
        end
        else if (argv[0] >= 16'd90 && argv[0] <= 16'd97)
        begin
            pidx = argv[0][7:0] - 8'd82;
        end
        else if (argv[0] >= 16'd100 && argv[0] <= 16'd107)
        begin
            pidx = argv[0][7:0] - 8'd92;
        end
        else
        begin
            pidx = argv[2][7:0];
        end
    end

    assign pal      = palette(pidx);
    assign tab_prod = 25'(col_reg) * 25'(TAB_RECIP);
    assign tab_col  = 9'((32'(tab_prod[24:16]) + 1) * TAB_STOP);
    assign take     = in_valid && in_ready;
    assign out_push = (pidx_reg < pcnt_reg) && !out_full;
    assign out_item = pend_reg[pidx_reg];
    assign in_ready = (pidx_reg == pcnt_reg) || ((pcnt_reg - pidx_reg == 2'd1) && out_push);
    assign aidx     = innum_reg ? IW'(total_reg - 1'b1) : IW'(total_reg);
    assign prod     = 20'(args_reg[aidx]) * 20'd10 + 20'(in_item.data[3:0]);

    always_comb
    begin
        result_t    cmds [3];
        logic [1:0] cnt;
        logic       do_ld;
        logic       ext_ok;
        logic [23:0] ext_rgb;
        logic [7:0] ns;
        logic [7:0] cw;
        logic [7:0] d;

        mode_next  = mode_reg;
        for (int k = 0; k < MAX_ARGS; k++)
        begin
            args_next[k] = args_reg[k];
        end
        total_next = total_reg;
        innum_next = innum_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        scol_next  = scol_reg;
        srow_next  = srow_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        attr_next  = attr_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        for (int k = 0; k < 3; k++)
        begin
            cmds[k]      = '0;
            pend_next[k] = pend_reg[k];
        end
        cnt     = 2'd0;
        do_ld   = 1'b0;
        d       = in_item.data;
        ns      = clamp_to(n, h);
        ext_ok  = 1'b0;
        ext_rgb = pal;
        cw      = (cfg_data == 8'd0) ? 8'd1 : cfg_data;

        // extended colour: 38/48 ;5;n or ;2;r;g;b
        if (tot8 >= 8'd2)
        begin
            if (argv[1] == SEL_INDEXED)
            begin
                ext_ok = (tot8 >= 8'd3) && (argv[2] <= 16'd255);
            end
            else if (argv[1] == SEL_DIRECT)
            begin
                ext_ok  = (tot8 >= 8'd5);
                ext_rgb = {argv[2][7:0], argv[3][7:0], argv[4][7:0]};
            end
        end

        pidx_next = pidx_reg;
        pcnt_next = pcnt_reg;
        if (out_push)
        begin
            pidx_next = pidx_reg + 2'd1;
        end

        if (take)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    priority if (in_item.cls == CLS_HIGH)
                    begin
                    end
                    else if (d == CH_BS)
                    begin
                        if (col_reg != 8'd0) col_next = col_reg - 8'd1;
                    end
                    else if (d == CH_TAB)
                    begin
                        if (tab_col >= {1'b0, w})
                        begin
                            do_ld    = 1'b1;
                            col_next = 8'd0;
                        end
                        else
                        begin
                            col_next = tab_col[7:0];
                        end
                    end
                    else if (d == CH_LF)
                    begin
                        col_next = 8'd0;
                        do_ld    = 1'b1;
                    end
                    else if (d == CH_VT)
                    begin
                        do_ld = 1'b1;
                    end
                    else if (d == CH_CR)
                    begin
                        col_next = 8'd0;
                    end
                    else if (d == CH_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (d == CH_DEL)
                    begin
                        if (col_reg != 8'd0)
                        begin
                            col_next  = col_reg - 8'd1;
                            cmds[cnt] = mk(CMD_ERASE, col_reg - 8'd1, row_reg,
                                           col_reg - 8'd1, row_reg, '0, '0);
                            cnt       = cnt + 2'd1;
                        end
                    end
                    else if (in_item.cls != CLS_CTRL)
                    begin
                        cmds[cnt] = mk(CMD_WRITE, col_reg, row_reg, col_reg, row_reg,
                                       '0, d[6:0]);
                        cnt       = cnt + 2'd1;
                        if ({1'b0, col_reg} + 9'd1 >= {1'b0, w})
                        begin
                            col_next = 8'd0;
                            do_ld    = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 8'd1;
                        end
                    end
                    else
                    begin
                    end
                    // line feed at the bottom row scrolls by one
                    if (do_ld)
                    begin
                        if ({1'b0, row_reg} + 9'd1 >= {1'b0, h})
                        begin
                            row_next  = hm1;
                            cmds[cnt] = mk(CMD_SCROLL, 8'd0, 8'd0, wm1, hm1, 9'sd1, '0);
                            cnt       = cnt + 2'd1;
                        end
                        else
                        begin
                            row_next = row_reg + 8'd1;
                        end
                    end
                end
                MODE_ESC:
                begin
                    for (int k = 0; k < MAX_ARGS; k++)
                    begin
                        args_next[k] = '0;
                    end
                    total_next = '0;
                    innum_next = 1'b0;
                    if (d == ESC_CSI)
                    begin
                        mode_next = MODE_CSI;
                    end
                    else if (d == ESC_SS2 || d == ESC_SS3 || d == ESC_DCS || d == ESC_ST ||
                             d == ESC_OSC || d == ESC_SOS || d == ESC_PM || d == ESC_APC)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_CSI:
                begin
                    if (in_item.cls == CLS_DIGIT)
                    begin
                        // a new argument past the last slot drops its digits
                        if (innum_reg || total_reg < TW'(MAX_ARGS))
                        begin
                            if (!innum_reg)
                            begin
                                total_next = total_reg + 1'b1;
                                innum_next = 1'b1;
                            end
                            args_next[aidx] = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                        end
                    end
                    else if (in_item.cls == CLS_SEP)
                    begin
                        innum_next = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        if (d == FIN_CUU)
                        begin
                            row_next = row_reg - clamp_to(n, row_reg);
                        end
                        else if (d == FIN_CUD)
                        begin
                            row_next = row_reg + clamp_to(n, hm1 - row_reg);
                        end
                        else if (d == FIN_CUF)
                        begin
                            col_next = col_reg + clamp_to(n, wm1 - col_reg);
                        end
                        else if (d == FIN_CUB)
                        begin
                            col_next = col_reg - clamp_to(n, col_reg);
                        end
                        else if (d == FIN_CNL)
                        begin
                            row_next = row_reg + clamp_to(n, hm1 - row_reg);
                            col_next = 8'd0;
                        end
                        else if (d == FIN_CPL)
                        begin
                            row_next = row_reg - clamp_to(n, row_reg);
                            col_next = 8'd0;
                        end
                        else if (d == FIN_CHA)
                        begin
                            col_next = clamp_to(n1, wm1);
                        end
                        else if (d == FIN_CUP || d == FIN_HVP)
                        begin
                            row_next = clamp_to(n1, hm1);
                            col_next = clamp_to(p1, wm1);
                        end
                        else if (d == FIN_ED)
                        begin
                            if (argv[0] == 16'd0)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, col_reg, row_reg, wm1, row_reg,
                                               '0, '0);
                                cnt       = cnt + 2'd1;
                                if (row_reg < hm1)
                                begin
                                    cmds[cnt] = mk(CMD_ERASE, 8'd0, row_reg + 8'd1, wm1, hm1,
                                                   '0, '0);
                                    cnt       = cnt + 2'd1;
                                end
                            end
                            else if (argv[0] == 16'd1)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, 8'd0, row_reg, col_reg, row_reg,
                                               '0, '0);
                                cnt       = cnt + 2'd1;
                                if (row_reg != 8'd0)
                                begin
                                    cmds[cnt] = mk(CMD_ERASE, 8'd0, 8'd0, wm1, row_reg - 8'd1,
                                                   '0, '0);
                                    cnt       = cnt + 2'd1;
                                end
                            end
                            else if (argv[0] == 16'd2 || argv[0] == 16'd3)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, 8'd0, 8'd0, wm1, hm1, '0, '0);
                                cnt       = cnt + 2'd1;
                            end
                        end
                        else if (d == FIN_EL)
                        begin
                            if (argv[0] == 16'd0)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, col_reg, row_reg, wm1, row_reg,
                                               '0, '0);
                                cnt       = cnt + 2'd1;
                            end
                            else if (argv[0] == 16'd1)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, 8'd0, row_reg, col_reg, row_reg,
                                               '0, '0);
                                cnt       = cnt + 2'd1;
                            end
                            else if (argv[0] == 16'd2)
                            begin
                                cmds[cnt] = mk(CMD_ERASE, 8'd0, row_reg, wm1, row_reg,
                                               '0, '0);
                                cnt       = cnt + 2'd1;
                            end
                        end
                        else if (d == FIN_SU)
                        begin
                            if (ns != 8'd0)
                            begin
                                cmds[cnt] = mk(CMD_SCROLL, 8'd0, 8'd0, wm1, hm1,
                                               $signed({1'b0, ns}), '0);
                                cnt       = cnt + 2'd1;
                            end
                        end
                        else if (d == FIN_SD)
                        begin
                            if (ns != 8'd0)
                            begin
                                cmds[cnt] = mk(CMD_SCROLL, 8'd0, 8'd0, wm1, hm1,
                                               -$signed({1'b0, ns}), '0);
                                cnt       = cnt + 2'd1;
                            end
                        end
                        else if (d == FIN_SGR)
                        begin
                            if ((argv[0] >= 16'd30 && argv[0] <= 16'd37) ||
                                (argv[0] >= 16'd90 && argv[0] <= 16'd97))
                            begin
                                fg_next = pal;
                            end
                            else if ((argv[0] >= 16'd40 && argv[0] <= 16'd47) ||
                                     (argv[0] >= 16'd100 && argv[0] <= 16'd107))
                            begin
                                bg_next = pal;
                            end
                            else
                            begin
                                unique case (argv[0])
                                    SGR_RESET:
                                    begin
                                        bg_next   = RGB_BLACK;
                                        fg_next   = RGB_WHITE;
                                        attr_next = '0;
                                    end
                                    SGR_BOLD:      attr_next = attr_reg | ATTR_BOLD;
                                    SGR_DIM:       attr_next = attr_reg | ATTR_DIM;
                                    SGR_ITALIC:    attr_next = attr_reg | ATTR_ITALIC;
                                    SGR_UNDER:     attr_next = attr_reg | ATTR_UNDER;
                                    SGR_BLINK:     attr_next = (attr_reg & ~ATTR_BLINK) | 9'd1;
                                    SGR_RBLINK:    attr_next = (attr_reg & ~ATTR_BLINK) | 9'd2;
                                    SGR_REVERSE:   attr_next = attr_reg | ATTR_REVERSE;
                                    SGR_HIDE:      attr_next = attr_reg | ATTR_BLINK;
                                    SGR_STRIKE:    attr_next = attr_reg | ATTR_STRIKE;
                                    SGR_NORMAL:    attr_next = attr_reg & ~(ATTR_BOLD | ATTR_DIM);
                                    SGR_NOITALIC:  attr_next = attr_reg & ~ATTR_ITALIC;
                                    SGR_NOUNDER:   attr_next = attr_reg & ~ATTR_UNDER;
                                    SGR_NOBLINK,
                                    SGR_SHOW:      attr_next = attr_reg & ~ATTR_BLINK;
                                    SGR_NOREVERSE: attr_next = attr_reg & ~ATTR_REVERSE;
                                    SGR_NOSTRIKE:  attr_next = attr_reg & ~ATTR_STRIKE;
                                    SGR_FG_EXT:    if (ext_ok) fg_next = ext_rgb;
                                    SGR_FG_DEF:    fg_next = RGB_GREY;
                                    SGR_BG_EXT:    if (ext_ok) bg_next = ext_rgb;
                                    SGR_BG_DEF:    bg_next = RGB_BLACK;
                                    SGR_OVER:      attr_next = attr_reg | ATTR_OVER;
                                    SGR_NOOVER:    attr_next = attr_reg & ~ATTR_OVER;
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        else if (d == FIN_SCP)
                        begin
                            scol_next = col_reg;
                            srow_next = row_reg;
                        end
                        else if (d == FIN_RCP)
                        begin
                            col_next = clamp_to(16'(scol_reg), wm1);
                            row_next = clamp_to(16'(srow_reg), hm1);
                        end
                    end
                end
                MODE_SKIP:
                begin
                    mode_next = MODE_NORMAL;
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            if (col_next != col_reg || row_next != row_reg)
            begin
                cmds[cnt] = mk(CMD_CURSOR, col_next, row_next, col_next, row_next, '0, '0);
                cnt       = cnt + 2'd1;
            end

            for (int k = 0; k < 3; k++)
            begin
                cmds[k].fg_rgb     = fg_reg;
                cmds[k].bg_rgb     = bg_reg;
                cmds[k].text_flags = attr_reg;
                cmds[k].last       = (cnt != 2'd0) && (2'(k) == cnt - 2'd1);
                pend_next[k]       = cmds[k];
            end
            pcnt_next = cnt;
            pidx_next = 2'd0;
        end

        // user keeps size writes to idle (unenforced); cursor pulled into new screen
        if (cfg_write)
        begin
            if (cfg_index == REG_COLUMNS)
            begin
                cols_next = cfg_data;
                col_next  = clamp_to(16'(col_reg), cw - 8'd1);
            end
            else
            begin
                rows_next = cfg_data;
                row_next  = clamp_to(16'(row_reg), cw - 8'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            for (int k = 0; k < MAX_ARGS; k++)
            begin
                args_reg[k] <= '0;
            end
            total_reg <= '0;
            innum_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            scol_reg  <= '0;
            srow_reg  <= '0;
            fg_reg    <= RGB_WHITE;
            bg_reg    <= RGB_BLACK;
            attr_reg  <= '0;
            cols_reg  <= 8'd80;
            rows_reg  <= 8'd25;
            pcnt_reg  <= '0;
            pidx_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            for (int k = 0; k < MAX_ARGS; k++)
            begin
                args_reg[k] <= args_next[k];
            end
            total_reg <= total_next;
            innum_reg <= innum_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            scol_reg  <= scol_next;
            srow_reg  <= srow_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            attr_reg  <= attr_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            pcnt_reg  <= pcnt_next;
            pidx_reg  <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pend_reg[k] <= pend_next[k];
        end
    end

endmodule

FILE: design/ansi_escape_terminal_parser_core.sv
// Terminal escape sequence parser driving an external character grid.
// Input channel: one terminal byte per item on in_byte, taken on push while
// full is low. Result channel: grid commands (write cell, erase rectangle,
// scroll rectangle, cursor moved) shown while empty is low, taken on pop.
// Each byte yields zero to three commands; last marks the final one.
// Configuration: cfg_write with cfg_index 0 sets columns, 1 sets rows; the
// cursor is clamped into the new size. Write only while the block is idle.
// Path: a front register that classifies the byte, a four entry byte queue,
// the execution stage that updates state and builds the byte's commands,
// and a four entry result queue. A byte passes the front register, the
// byte queue, the execution stage's command registers and the result queue
// before its first command is shown. The execution stage hands a byte's
// commands to the result queue one per cycle while that queue is not full.
// When pop stays low the result queue fills, the execution stage holds,
// the byte queue fills and full rises; no item is lost.
// Reset clears parser state, cursor and attributes, sets the screen to
// 80 by 25 and empties both queues.
module ansi_escape_terminal_parser_core
    import aetp_pkg::*;
#(
    parameter int MAX_ARGS = 8,
    parameter int TAB_STOP = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_byte,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        command,
    output logic [7:0]        left_col,
    output logic [7:0]        top_row,
    output logic [7:0]        right_col,
    output logic [7:0]        bottom_row,
    output logic signed [8:0] scroll_amount,
    output logic [6:0]        glyph,
    output logic [23:0]       fg_rgb,
    output logic [23:0]       bg_rgb,
    output logic [8:0]        text_flags,
    output logic              last
);
    byte_item_t fq_in, fq_out;
    logic       fq_push, fq_full, fq_empty, fq_pop;
    result_t    rq_in, rq_out;
    logic       rq_push, rq_full;

    aetp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_byte (in_byte),
        .full    (full),
        .q_full  (fq_full),
        .q_push  (fq_push),
        .q_item  (fq_in)
    );

    aetp_fifo #(.WIDTH($bits(byte_item_t)), .DEPTH(QUEUE_DEPTH)) u_byte_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_in),
        .rd_en   (fq_pop),
        .rd_data (fq_out),
        .full    (fq_full),
        .empty   (fq_empty)
    );

    aetp_back #(.MAX_ARGS(MAX_ARGS), .TAB_STOP(TAB_STOP)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (!fq_empty),
        .in_item   (fq_out),
        .in_ready  (fq_pop),
        .out_full  (rq_full),
        .out_push  (rq_push),
        .out_item  (rq_in)
    );

    aetp_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (rq_in),
        .rd_en   (pop),
        .rd_data (rq_out),
        .full    (rq_full),
        .empty   (empty)
    );

    assign command       = rq_out.command;
    assign left_col      = rq_out.left_col;
    assign top_row       = rq_out.top_row;
    assign right_col     = rq_out.right_col;
    assign bottom_row    = rq_out.bottom_row;
    assign scroll_amount = rq_out.scroll_amount;
    assign glyph         = rq_out.glyph;
    assign fg_rgb        = rq_out.fg_rgb;
    assign bg_rgb        = rq_out.bg_rgb;
    assign text_flags    = rq_out.text_flags;
    assign last          = rq_out.last;

endmodule

FILE: design/aetp_checker.sv
// port level checks of the parser core and their binding
module aetp_checker
    import aetp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [1:0]        command,
    input logic [7:0]        left_col,
    input logic [7:0]        top_row,
    input logic [7:0]        right_col,
    input logic [7:0]        bottom_row,
    input logic signed [8:0] scroll_amount,
    input logic [6:0]        glyph
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_write_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command == CMD_WRITE) |->
        (left_col == right_col && top_row == bottom_row &&
         glyph >= 7'h20 && glyph != 7'h7F))
        else $error("write cell item malformed");

    a_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command != CMD_WRITE) |-> (glyph == 7'd0))
        else $error("glyph set on a non write item");

    a_amount_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command != CMD_SCROLL) |-> (scroll_amount == 9'sd0))
        else $error("scroll amount set on a non scroll item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(command) && $stable(left_col) &&
                              $stable(top_row)))
        else $error("stalled result item changed");

endmodule

bind ansi_escape_terminal_parser_core aetp_checker u_checker (.*);

FILE: test/ansi_escape_terminal_parser_core_tb.sv
// self-checking testbench of the terminal escape parser core
module ansi_escape_terminal_parser_core_tb;
    import aetp_pkg::*;

    localparam int ARG_SLOTS  = 8;
    localparam int TAB_WIDTH  = 8;
    localparam int DRAIN_WAIT = 24;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 80;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_COLUMNS;
    logic [7:0]        cfg_data = 8'd0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        in_byte = 8'd0;
    logic              empty;
    logic              pop = 1'b0;
    logic [1:0]        command;
    logic [7:0]        left_col, top_row, right_col, bottom_row;
    logic signed [8:0] scroll_amount;
    logic [6:0]        glyph;
    logic [23:0]       fg_rgb, bg_rgb;
    logic [8:0]        text_flags;
    logic              last;

    ansi_escape_terminal_parser_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full), .in_byte(in_byte),
        .empty(empty), .pop(pop),
        .command(command), .left_col(left_col), .top_row(top_row),
        .right_col(right_col), .bottom_row(bottom_row),
        .scroll_amount(scroll_amount), .glyph(glyph),
        .fg_rgb(fg_rgb), .bg_rgb(bg_rgb), .text_flags(text_flags), .last(last)
    );

    always #5 clk = ~clk;

    // shadow terminal state
    int unsigned scr_cols, scr_rows;
    mode_t       pmode;
    int unsigned num_arg [ARG_SLOTS];
    int unsigned num_count, in_digits;
    int unsigned cur_col, cur_row, mark_col, mark_row;
    int unsigned fg_now, bg_now, flags_now;

    logic [7:0] byte_queue [$];
    result_t    grid_cmds [$];
    result_t    byte_cmds [$];

    int errors = 0;
    int bytes_sent = 0;
    int cmds_seen = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int send_gap = 0;
    int take_gap = 0;

    function automatic logic [23:0] ega_colour(int unsigned i);
        logic [23:0] tbl [16] = '{24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
                                  24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
                                  24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
                                  24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF};
        return tbl[i];
    endfunction

    function automatic int unsigned cube_step(int unsigned x);
        return x ? 32'h37 + 32'h28 * x : 0;
    endfunction

    function automatic int unsigned colour_of(int unsigned i);
        int unsigned k;
        k = i - 16;
        if (i < 16) return ega_colour(i);
        if (i < 232)
            return (cube_step(k / 36) << 16) | (cube_step((k / 6) % 6) << 8) | cube_step(k % 6);
        return (8 + 10 * (i - 232)) * 32'h010101;
    endfunction

    function automatic int unsigned width_now();
        return scr_cols ? scr_cols : 1;
    endfunction

    function automatic int unsigned height_now();
        return scr_rows ? scr_rows : 1;
    endfunction

    function automatic int unsigned arg_at(int unsigned i);
        return (i < num_count) ? num_arg[i] : 0;
    endfunction

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    task automatic emit_cmd(cmd_t c, int unsigned l, int unsigned t, int unsigned r,
                            int unsigned b, int amt, int unsigned g);
        result_t x;
        if (byte_cmds.size() >= 3) return;
        x.command       = c;
        x.left_col      = 8'(l);
        x.top_row       = 8'(t);
        x.right_col     = 8'(r);
        x.bottom_row    = 8'(b);
        x.scroll_amount = 9'(amt);
        x.glyph         = 7'(g);
        x.fg_rgb        = 24'(fg_now);
        x.bg_rgb        = 24'(bg_now);
        x.text_flags    = 9'(flags_now);
        x.last          = 1'b0;
        byte_cmds.push_back(x);
    endtask

    task automatic scroll_screen(int amt);
        emit_cmd(CMD_SCROLL, 0, 0, width_now() - 1, height_now() - 1, amt, 0);
    endtask

    task automatic next_line();
        cur_row++;
        if (cur_row >= height_now())
        begin
            cur_row = height_now() - 1;
            scroll_screen(1);
        end
    endtask

    function automatic int unsigned pick_colour(int unsigned old);
        if (num_count < 2) return old;
        if (arg_at(1) == 5)
        begin
            if (num_count < 3 || arg_at(2) > 255) return old;
            return colour_of(arg_at(2));
        end
        if (arg_at(1) == 2)
        begin
            if (num_count < 5) return old;
            return ((arg_at(2) & 8'hFF) << 16) | ((arg_at(3) & 8'hFF) << 8) | (arg_at(4) & 8'hFF);
        end
        return old;
    endfunction

    task automatic put_flags(int unsigned mask, int unsigned val);
        flags_now = (flags_now & ~mask & 9'h1FF) | (val & mask);
    endtask

    task automatic apply_sgr();
        int unsigned op;
        op = num_count < 1 ? 0 : arg_at(0);
        if (op >= 30 && op <= 37) fg_now = colour_of(op - 30);
        else if (op >= 40 && op <= 47) bg_now = colour_of(op - 40);
        else if (op >= 90 && op <= 97) fg_now = colour_of(op - 82);
        else if (op >= 100 && op <= 107) bg_now = colour_of(op - 92);
        else
            case (op)
                0:  begin bg_now = 0; fg_now = RGB_WHITE; flags_now = 0; end
                1:  put_flags(9'h004, 9'h004);
                2:  put_flags(9'h008, 9'h008);
                3:  put_flags(9'h010, 9'h010);
                4:  put_flags(9'h020, 9'h020);
                5:  put_flags(9'h003, 1);
                6:  put_flags(9'h003, 2);
                7:  put_flags(9'h100, 9'h100);
                8:  put_flags(9'h003, 3);
                9:  put_flags(9'h040, 9'h040);
                22: put_flags(9'h00C, 0);
                23: put_flags(9'h010, 0);
                24: put_flags(9'h020, 0);
                25, 28: put_flags(9'h003, 0);
                27: put_flags(9'h100, 0);
                29: put_flags(9'h040, 0);
                38: fg_now = pick_colour(fg_now);
                39: fg_now = colour_of(7);
                48: bg_now = pick_colour(bg_now);
                49: bg_now = colour_of(0);
                53: put_flags(9'h080, 9'h080);
                55: put_flags(9'h080, 0);
                default: ;
            endcase
    endtask

    task automatic csi_byte(int unsigned b);
        int unsigned w, h, n, opt, p;
        w   = width_now();
        h   = height_now();
        n   = num_count < 1 ? 1 : arg_at(0);
        opt = num_count < 1 ? 0 : arg_at(0);
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            if (!in_digits)
            begin
                if (num_count >= ARG_SLOTS) return;
                num_count++;
                in_digits = 1;
            end
            p = num_arg[num_count - 1] * 10 + (b - CH_ZERO);
            num_arg[num_count - 1] = p > 65535 ? 65535 : p;
            return;
        end
        if (b == CH_SEMI || b == CH_COLON)
        begin
            in_digits = 0;
            return;
        end
        pmode = MODE_NORMAL;
        case (b)
            "A": cur_row -= umin(n, cur_row);
            "B": cur_row += umin(n, h - 1 - cur_row);
            "C": cur_col += umin(n, w - 1 - cur_col);
            "D": cur_col -= umin(n, cur_col);
            "E": begin cur_row += umin(n, h - 1 - cur_row); cur_col = 0; end
            "F": begin cur_row -= umin(n, cur_row); cur_col = 0; end
            "G": cur_col = umin(n ? n - 1 : 0, w - 1);
            "H", "f":
            begin
                p = num_count < 2 ? 1 : arg_at(1);
                cur_row = umin(n ? n - 1 : 0, h - 1);
                cur_col = umin(p ? p - 1 : 0, w - 1);
            end
            "J":
                if (opt == 0)
                begin
                    emit_cmd(CMD_ERASE, cur_col, cur_row, w - 1, cur_row, 0, 0);
                    if (cur_row < h - 1) emit_cmd(CMD_ERASE, 0, cur_row + 1, w - 1, h - 1, 0, 0);
                end
                else if (opt == 1)
                begin
                    emit_cmd(CMD_ERASE, 0, cur_row, cur_col, cur_row, 0, 0);
                    if (cur_row > 0) emit_cmd(CMD_ERASE, 0, 0, w - 1, cur_row - 1, 0, 0);
                end
                else if (opt == 2 || opt == 3) emit_cmd(CMD_ERASE, 0, 0, w - 1, h - 1, 0, 0);
            "K":
                if (opt == 0) emit_cmd(CMD_ERASE, cur_col, cur_row, w - 1, cur_row, 0, 0);
                else if (opt == 1) emit_cmd(CMD_ERASE, 0, cur_row, cur_col, cur_row, 0, 0);
                else if (opt == 2) emit_cmd(CMD_ERASE, 0, cur_row, w - 1, cur_row, 0, 0);
            "S": begin n = umin(n, h); if (n) scroll_screen(n); end
            "T": begin n = umin(n, h); if (n) scroll_screen(-int'(n)); end
            "m": apply_sgr();
            "s": begin mark_col = cur_col; mark_row = cur_row; end
            "u":
            begin
                cur_col = umin(mark_col, w - 1);
                cur_row = umin(mark_row, h - 1);
            end
            default: ;
        endcase
    endtask

    task automatic text_byte(int unsigned b);
        if (b >= 8'h80) return;
        case (b)
            CH_BS: if (cur_col > 0) cur_col--;
            CH_TAB:
            begin
                cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
                if (cur_col >= width_now())
                begin
                    next_line();
                    cur_col = 0;
                end
            end
            CH_LF: begin cur_col = 0; next_line(); end
            CH_VT: next_line();
            CH_CR: cur_col = 0;
            CH_ESC: pmode = MODE_ESC;
            CH_DEL:
                if (cur_col > 0)
                begin
                    cur_col--;
                    emit_cmd(CMD_ERASE, cur_col, cur_row, cur_col, cur_row, 0, 0);
                end
            default:
                if (b >= CH_SPACE)
                begin
                    emit_cmd(CMD_WRITE, cur_col, cur_row, cur_col, cur_row, 0, b);
                    cur_col++;
                    if (cur_col >= width_now())
                    begin
                        cur_col = 0;
                        next_line();
                    end
                end
        endcase
    endtask

    // expected commands of one accepted byte
    task automatic predict_byte(logic [7:0] b);
        int unsigned oc, orw;
        oc  = cur_col;
        orw = cur_row;
        byte_cmds.delete();
        case (pmode)
            MODE_NORMAL: text_byte(b);
            MODE_ESC:
            begin
                foreach (num_arg[i]) num_arg[i] = 0;
                num_count = 0;
                in_digits = 0;
                if (b == "[") pmode = MODE_CSI;
                else if (b inside {"N", "O", "P", "\\", "]", "X", "^", "_"}) pmode = MODE_SKIP;
                else pmode = MODE_NORMAL;
            end
            MODE_CSI: csi_byte(b);
            default: pmode = MODE_NORMAL;
        endcase
        if (cur_col != oc || cur_row != orw)
            emit_cmd(CMD_CURSOR, cur_col, cur_row, cur_col, cur_row, 0, 0);
        if (byte_cmds.size() > 0) byte_cmds[byte_cmds.size() - 1].last = 1'b1;
        foreach (byte_cmds[i]) grid_cmds.push_back(byte_cmds[i]);
    endtask

    task automatic add_byte(logic [7:0] b);
        byte_queue.push_back(b);
    endtask

    task automatic add_csi(string s);
        add_byte(CH_ESC);
        add_byte("[");
        foreach (s[i]) add_byte(s[i]);
    endtask

    task automatic add_number(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        foreach (s[i]) add_byte(s[i]);
    endtask

    function automatic int unsigned rand_arg();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(100, 300);
            2:       return 9999999;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // one random sequence, mostly well formed
    task automatic add_random_seq();
        string finals;
        int unsigned k, na;
        logic [7:0] sel;
        finals = "ABCDEFGHfJKSTmsu";
        case ($urandom_range(0, 11))
            0, 1, 2:
                repeat ($urandom_range(1, 6)) add_byte($urandom_range(8'h20, 8'h7E));
            3:
            begin
                sel = $urandom_range(0, 6);
                case (sel)
                    0: add_byte(CH_BS);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_LF);
                    3: add_byte(CH_VT);
                    4: add_byte(CH_CR);
                    5: add_byte(CH_DEL);
                    default: add_byte($urandom_range(0, 8'h1F));
                endcase
            end
            4, 5, 6:
            begin
                add_byte(CH_ESC);
                add_byte("[");
                na = ($urandom_range(0, 15) == 0) ? 9 : $urandom_range(0, 3);
                for (k = 0; k < na; k++)
                begin
                    if (k) add_byte($urandom_range(0, 3) ? CH_SEMI : CH_COLON);
                    if ($urandom_range(0, 9)) add_number(rand_arg());
                end
                add_byte($urandom_range(0, 12) ? finals[$urandom_range(0, finals.len() - 1)]
                                               : $urandom_range(0, 255));
            end
            7, 8:
            begin
                k = $urandom_range(0, 3);
                add_byte(CH_ESC);
                add_byte("[");
                if (k == 0)
                begin
                    add_number($urandom_range(0, 1) ? 38 : 48);
                    add_byte(CH_SEMI);
                    add_byte("5");
                    add_byte(CH_SEMI);
                    add_number($urandom_range(0, 300));
                end
                else if (k == 1)
                begin
                    add_number($urandom_range(0, 1) ? 38 : 48);
                    add_byte(CH_SEMI);
                    add_byte("2");
                    repeat (3)
                    begin
                        add_byte(CH_SEMI);
                        add_number($urandom_range(0, 400));
                    end
                end
                else
                    add_number($urandom_range(0, 110));
                add_byte("m");
            end
            9:
            begin
                add_byte(CH_ESC);
                add_byte($urandom_range(0, 1) ? "]" : $urandom_range(0, 255));
                add_byte($urandom_range(0, 255));
            end
            default:
                add_byte($urandom_range(0, 255));
        endcase
    endtask

    task automatic add_random_bytes(int n);
        int goal;
        goal = byte_queue.size() + n;
        while (byte_queue.size() < goal) add_random_seq();
    endtask

    task automatic wait_idle();
        wait (byte_queue.size() == 0 && !push);
        wait (grid_cmds.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_COLUMNS) scr_cols = val;
        else scr_rows = val;
        cur_col = umin(cur_col, width_now() - 1);
        cur_row = umin(cur_row, height_now() - 1);
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_byte(byte_queue.pop_front());
                bytes_sent++;
                if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (byte_queue.size() == 0)
                push <= 1'b0;
            else
            begin
                push    <= 1'b1;
                in_byte <= byte_queue[0];
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                cmds_seen++;
                if (grid_cmds.size() == 0)
                begin
                    $error("command %0d arrived with nothing expected", command);
                    errors++;
                end
                else
                begin
                    result_t e;
                    e = grid_cmds.pop_front();
                    check_field("command", e.command, command);
                    check_field("left_col", e.left_col, left_col);
                    check_field("top_row", e.top_row, top_row);
                    check_field("right_col", e.right_col, right_col);
                    check_field("bottom_row", e.bottom_row, bottom_row);
                    check_field("scroll_amount", e.scroll_amount, scroll_amount);
                    check_field("glyph", e.glyph, glyph);
                    check_field("fg_rgb", e.fg_rgb, fg_rgb);
                    check_field("bg_rgb", e.bg_rgb, bg_rgb);
                    check_field("text_flags", e.text_flags, text_flags);
                    check_field("last", e.last, last);
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                take_gap = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on stalled progress
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d bytes and %0d commands pending",
                     byte_queue.size(), grid_cmds.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        scr_cols  = 80;
        scr_rows  = 25;
        pmode     = MODE_NORMAL;
        foreach (num_arg[i]) num_arg[i] = 0;
        num_count = 0;
        in_digits = 0;
        cur_col   = 0;
        cur_row   = 0;
        mark_col  = 0;
        mark_row  = 0;
        fg_now    = RGB_WHITE;
        bg_now    = RGB_BLACK;
        flags_now = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: printable extremes, controls, high bytes, key sequences
        add_byte(CH_SPACE);
        add_byte(8'h7E);
        add_byte(CH_TAB);
        add_byte(CH_BS);
        add_byte(CH_DEL);
        add_byte(8'h80);
        add_byte(8'hFF);
        add_csi("99999999;300H");
        add_byte("Z");
        add_csi("0A");
        add_csi("1J");
        add_csi("38;5;300m");
        add_csi("S");
        add_byte(CH_ESC);
        add_byte("P");
        add_byte(CH_ESC);
        wait_idle();

        // biggest screen, with a long receiver hold-off
        write_reg(REG_COLUMNS, 8'd255);
        write_reg(REG_ROWS, 8'd255);
        add_random_bytes(40);
        hold_req = 1'b1;
        wait_idle();

        // zero sizes behave as one cell
        write_reg(REG_COLUMNS, 8'd0);
        write_reg(REG_ROWS, 8'd0);
        add_random_bytes(30);
        wait_idle();

        write_reg(REG_COLUMNS, 8'd1);
        write_reg(REG_ROWS, 8'd1);
        add_random_bytes(15);
        wait_idle();

        write_reg(REG_COLUMNS, 8'($urandom_range(2, 40)));
        write_reg(REG_ROWS, 8'($urandom_range(2, 12)));
        add_random_bytes(45);
        wait_idle();

        quiet = 1'b1;
        write_reg(REG_COLUMNS, 8'd80);
        write_reg(REG_ROWS, 8'd4);
        add_random_bytes(40);
        wait_idle();

        if (grid_cmds.size() != 0)
        begin
            $error("%0d commands never arrived", grid_cmds.size());
            errors += grid_cmds.size();
        end
        $display("sent %0d bytes and checked %0d grid commands", bytes_sent, cmds_seen);
        $display("screens from one cell to 255 by 255, with a full-queue stall");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
